/* rtl/tlj_pkg.sv */
`default_nettype none
package tlj_pkg;
	localparam int MAX_WIDTH_DEF = 31;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_BOM0 = 8'hEF;
	localparam logic [7:0] CH_BOM1 = 8'hBB;
	localparam logic [7:0] CH_BOM2 = 8'hBF;

	typedef enum logic [1:0] {
		CMD_CHAR = 2'd0,
		CMD_SEP = 2'd1,
		CMD_END = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [7:0] ch;
	} token_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_CLOSE = 3'd1,
		ST_COPY = 3'd2,
		ST_EMIT = 3'd3,
		ST_PAD = 3'd4,
		ST_LF = 3'd5,
		ST_DIV = 3'd6,
		ST_APPEND = 3'd7
	} state_t;
endpackage
`default_nettype wire

/* rtl/text_line_justifier.sv */
`default_nettype none
// Greedy text justifier. Bytes are pushed into a two-entry token queue and a
// sequencer builds words and lines in two small RAMs. A plain letter is written
// straight into the word RAM. Closing a word copies its letters and a space
// into the line RAM. A line flush first divides the spare columns by repeated
// subtraction to get the per-gap padding, then emits the line bytes through
// the registered read of the line RAM, the padding spaces and, except for the
// final line, a line feed. Results leave through a one-entry output register,
// and the sequencer waits while that register holds an unaccepted transfer.
// Write the line width only while the block is idle.
module text_line_justifier #(
	parameter int MAX_WIDTH = tlj_pkg::MAX_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [7:0] text_byte,
	input wire logic end_of_text,
	output logic empty,
	input wire logic pop,
	output logic [7:0] out_byte,
	output logic run_last,
	input wire logic cfg_we,
	input wire logic [4:0] cfg_wdata
);
	logic [4:0] width_q;
	logic tok_valid, tok_ready;
	tlj_pkg::token_t tok;
	logic o_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 5'd31;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	tlj_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.text_byte(text_byte), .end_of_text(end_of_text),
		.tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok)
	);

	tlj_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .width(width_q),
		.tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok),
		.o_valid(o_valid), .o_ready(pop), .o_byte(out_byte), .o_last(run_last)
	);

	assign empty = !o_valid;
endmodule
`default_nettype wire

/* rtl/tlj_ram.sv */
`default_nettype none
module tlj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/tlj_front.sv */
`default_nettype none
module tlj_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [7:0] text_byte,
	input wire logic end_of_text,
	output logic tok_valid,
	input wire logic tok_ready,
	output tlj_pkg::token_t tok
);
	tlj_pkg::token_t tok_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic wr_q;
	tlj_pkg::token_t in_tok;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == 2'd2);
	assign tok_valid = (cnt_q != 2'd0);
	assign tok = tok_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = tok_valid && tok_ready;

	always_comb begin
		in_tok.ch = text_byte;
		if (end_of_text) begin
			in_tok.cmd = tlj_pkg::CMD_END;
		end else if (text_byte == tlj_pkg::CH_SPACE || text_byte == tlj_pkg::CH_LF
				|| text_byte == tlj_pkg::CH_TAB || text_byte == tlj_pkg::CH_BOM0
				|| text_byte == tlj_pkg::CH_BOM1 || text_byte == tlj_pkg::CH_BOM2) begin
			in_tok.cmd = tlj_pkg::CMD_SEP;
		end else begin
			in_tok.cmd = tlj_pkg::CMD_CHAR;
			if (text_byte[7]) begin
				in_tok.ch = tlj_pkg::CH_QUEST;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			tok_q[wr_q] <= in_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

/* rtl/tlj_back.sv */
`default_nettype none
module tlj_back #(
	parameter int MAX_WIDTH = tlj_pkg::MAX_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [4:0] width,
	input wire logic tok_valid,
	output logic tok_ready,
	input wire tlj_pkg::token_t tok,
	output logic o_valid,
	input wire logic o_ready,
	output logic [7:0] o_byte,
	output logic o_last
);
	localparam int WAW = $clog2(MAX_WIDTH);
	localparam int LAW = $clog2(MAX_WIDTH + 1);

	tlj_pkg::state_t state_q, state_d;
	tlj_pkg::cmd_t cmd_q;
	logic [5:0] wlen_q;
	logic [5:0] llen_q;
	logic [5:0] words_q;
	logic between_q;
	logic [5:0] idx_q;
	logic [5:0] len_q;
	logic pad_q;
	logic fin_q;
	logic [5:0] q_q;
	logic [5:0] r_q;
	logic [5:0] gap_q;
	logic [5:0] padc_q;
	logic [5:0] rem_q;
	logic [5:0] gaps_q;
	logic rdy_q;
	logic pend_q;

	logic w_we;
	logic [WAW-1:0] w_waddr, w_raddr;
	logic [7:0] w_wdata, w_rdata;
	logic l_we;
	logic [LAW-1:0] l_waddr, l_raddr;
	logic [7:0] l_wdata, l_rdata;

	logic [5:0] weff;
	logic out_busy;
	logic flush_now;
	logic div_setup;
	logic div_more;
	logic emit_ch;
	logic is_gap;
	logic emit;
	logic [7:0] emit_byte;
	logic emit_last;

	assign weff = (width > 5'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : {1'b0, width};
	assign out_busy = o_valid && !o_ready;
	assign flush_now = (7'(wlen_q) + 7'(llen_q) + 7'd1 >= 7'(weff));
	assign div_setup = (padc_q == 6'd0 && gaps_q == 6'd0);
	assign div_more = pad_q && rem_q >= gaps_q;
	assign emit_ch = (idx_q < len_q) && !out_busy && rdy_q;
	assign is_gap = (l_rdata == tlj_pkg::CH_SPACE) && pad_q;

	tlj_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_word (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);
	tlj_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH + 1)) u_line (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	assign w_we = (state_q == tlj_pkg::ST_IDLE) && tok_valid
		&& tok.cmd == tlj_pkg::CMD_CHAR && wlen_q < 6'(MAX_WIDTH);
	assign w_waddr = wlen_q[WAW-1:0];
	assign w_wdata = tok.ch;
	assign w_raddr = idx_q[WAW-1:0];
	assign l_raddr = idx_q[LAW-1:0];

	always_comb begin
		l_we = 1'b0;
		l_wdata = w_rdata;
		if (state_q == tlj_pkg::ST_APPEND && llen_q < 6'(MAX_WIDTH + 1)) begin
			l_we = 1'b1;
			l_wdata = pend_q ? w_rdata : tlj_pkg::CH_SPACE;
		end
	end
	assign l_waddr = llen_q[LAW-1:0];

	assign tok_ready = (state_q == tlj_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tlj_pkg::ST_IDLE: begin
				if (tok_valid) begin
					if (tok.cmd == tlj_pkg::CMD_CHAR) begin
						state_d = tlj_pkg::ST_IDLE;
					end else if (!between_q) begin
						state_d = tlj_pkg::ST_CLOSE;
					end else if (tok.cmd == tlj_pkg::CMD_END) begin
						state_d = tlj_pkg::ST_DIV;
					end
				end
			end
			tlj_pkg::ST_CLOSE: begin
				state_d = flush_now ? tlj_pkg::ST_DIV : tlj_pkg::ST_COPY;
			end
			tlj_pkg::ST_DIV: begin
				if (llen_q == 6'd0) begin
					state_d = tlj_pkg::ST_LF;
				end else if (!div_setup && !div_more) begin
					state_d = tlj_pkg::ST_EMIT;
				end
			end
			tlj_pkg::ST_EMIT: begin
				if (idx_q >= len_q) begin
					state_d = tlj_pkg::ST_LF;
				end else if (emit_ch && is_gap && (q_q != 6'd0 || gap_q < r_q)) begin
					state_d = tlj_pkg::ST_PAD;
				end
			end
			tlj_pkg::ST_PAD: begin
				if (!out_busy && padc_q == 6'd1) begin
					state_d = tlj_pkg::ST_EMIT;
				end
			end
			tlj_pkg::ST_LF: begin
				if (!out_busy) begin
					state_d = fin_q ? tlj_pkg::ST_IDLE : tlj_pkg::ST_COPY;
				end
			end
			tlj_pkg::ST_COPY: begin
				state_d = tlj_pkg::ST_APPEND;
			end
			tlj_pkg::ST_APPEND: begin
				if (pend_q) begin
					state_d = tlj_pkg::ST_COPY;
				end else if (cmd_q == tlj_pkg::CMD_END) begin
					state_d = tlj_pkg::ST_DIV;
				end else begin
					state_d = tlj_pkg::ST_IDLE;
				end
			end
			default: state_d = tlj_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		emit_byte = l_rdata;
		emit_last = 1'b0;
		case (state_q)
			tlj_pkg::ST_EMIT: begin
				if (emit_ch) begin
					emit = 1'b1;
					emit_byte = l_rdata;
					emit_last = fin_q && (idx_q + 6'd1 >= len_q);
				end
			end
			tlj_pkg::ST_PAD: begin
				if (!out_busy) begin
					emit = 1'b1;
					emit_byte = tlj_pkg::CH_SPACE;
				end
			end
			tlj_pkg::ST_LF: begin
				if (!out_busy && !fin_q && llen_q != 6'd0) begin
					emit = 1'b1;
					emit_byte = tlj_pkg::CH_LF;
					emit_last = (cmd_q == tlj_pkg::CMD_SEP);
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid <= 1'b0;
			o_byte <= '0;
			o_last <= 1'b0;
		end else if (emit) begin
			o_valid <= 1'b1;
			o_byte <= emit_byte;
			o_last <= emit_last;
		end else if (o_ready) begin
			o_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlj_pkg::ST_IDLE;
			cmd_q <= tlj_pkg::CMD_CHAR;
			wlen_q <= '0;
			llen_q <= '0;
			words_q <= '0;
			between_q <= 1'b1;
			idx_q <= '0;
			len_q <= '0;
			pad_q <= 1'b0;
			fin_q <= 1'b0;
			q_q <= '0;
			r_q <= '0;
			gap_q <= '0;
			padc_q <= '0;
			rem_q <= '0;
			gaps_q <= '0;
			rdy_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				tlj_pkg::ST_IDLE: begin
					if (tok_valid) begin
						cmd_q <= tok.cmd;
						if (tok.cmd == tlj_pkg::CMD_CHAR) begin
							if (wlen_q < 6'(MAX_WIDTH)) begin
								wlen_q <= wlen_q + 6'd1;
							end
							between_q <= 1'b0;
						end else if (!between_q) begin
							between_q <= 1'b1;
						end else if (tok.cmd == tlj_pkg::CMD_END) begin
							fin_q <= 1'b1;
						end
					end
				end
				tlj_pkg::ST_CLOSE: begin
					if (flush_now) begin
						fin_q <= 1'b0;
					end else begin
						idx_q <= '0;
					end
				end
				tlj_pkg::ST_DIV: begin
					// Flush setup: gap count and spare columns, then divide by subtraction.
					if (llen_q == 6'd0) begin
						len_q <= '0;
					end else if (div_setup) begin
						len_q <= llen_q - 6'd1;
						pad_q <= !fin_q && words_q >= 6'd2 && (llen_q - 6'd1) <= weff;
						gaps_q <= words_q - 6'd1;
						rem_q <= weff - (llen_q - 6'd1);
						q_q <= '0;
						padc_q <= 6'd1;
					end else if (div_more) begin
						rem_q <= rem_q - gaps_q;
						q_q <= q_q + 6'd1;
					end else begin
						r_q <= rem_q;
						padc_q <= '0;
						gaps_q <= '0;
						gap_q <= '0;
						idx_q <= '0;
						rdy_q <= 1'b0;
					end
				end
				tlj_pkg::ST_EMIT: begin
					if (idx_q < len_q && !out_busy) begin
						if (!rdy_q) begin
							rdy_q <= 1'b1;
						end else begin
							rdy_q <= 1'b0;
							idx_q <= idx_q + 6'd1;
							if (is_gap) begin
								padc_q <= q_q + ((gap_q < r_q) ? 6'd1 : 6'd0);
								gap_q <= gap_q + 6'd1;
							end
						end
					end
				end
				tlj_pkg::ST_PAD: begin
					if (!out_busy) begin
						padc_q <= padc_q - 6'd1;
					end
				end
				tlj_pkg::ST_LF: begin
					if (!out_busy) begin
						llen_q <= '0;
						words_q <= '0;
						len_q <= '0;
						if (fin_q) begin
							wlen_q <= '0;
							between_q <= 1'b1;
							fin_q <= 1'b0;
						end else begin
							idx_q <= '0;
						end
					end
				end
				tlj_pkg::ST_COPY: begin
					pend_q <= (idx_q < wlen_q);
				end
				tlj_pkg::ST_APPEND: begin
					if (llen_q < 6'(MAX_WIDTH + 1)) begin
						llen_q <= llen_q + 6'd1;
					end
					if (pend_q) begin
						idx_q <= idx_q + 6'd1;
					end else begin
						words_q <= words_q + 6'd1;
						wlen_q <= '0;
						if (cmd_q == tlj_pkg::CMD_END) begin
							fin_q <= 1'b1;
						end
					end
				end
				default: cmd_q <= tlj_pkg::CMD_CHAR;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/tlj_checker.sv */
`default_nettype none
module tlj_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire logic [7:0] out_byte
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte)) else $error("result dropped");
	a_rst: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("reset output");
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !out_byte[7]) else $error("non-ASCII byte");
endmodule

bind text_line_justifier tlj_checker u_chk (
	.clk(clk), .arst_n(arst_n), .full(full),
	.empty(empty), .pop(pop), .out_byte(out_byte)
);
`default_nettype wire

/* tb/sv/tb_top.sv */
module tb_top;
	typedef struct {
		logic [7:0] text;
		logic       eot;
		logic       typed;
		logic [7:0] out0;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} jbyte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_wdata = 5'd0;

	text_line_justifier dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.text_byte(text_byte), .end_of_text(end_of_text),
		.empty(empty), .pop(pop), .out_byte(out_byte), .run_last(run_last),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Predictor state.
	logic [7:0] word_buf [tlj_pkg::MAX_WIDTH_DEF];
	logic [7:0] line_buf [tlj_pkg::MAX_WIDTH_DEF + 1];
	int unsigned word_len, line_len, word_cnt, width_reg;
	bit in_gap;
	jbyte_t just_q [$];
	jbyte_t step_q [$];

	int errors = 0;
	int pushed = 0;
	int popped = 0;
	bit quiet_in = 1'b0;
	bit quiet_out = 1'b0;

	task automatic report(input string what, input jbyte_t got, input jbyte_t want);
		$display("MISMATCH %s: got %h/%b want %h/%b at %0t",
			what, got.ch, got.last, want.ch, want.last, $time);
		errors++;
	endtask

	function automatic void emit(input logic [7:0] c);
		if (step_q.size() < 63)
			step_q.push_back('{ch: c, last: 1'b0});
	endfunction

	function automatic void flush_line(input bit final_line);
		int unsigned len, w, q, r, gap;
		bit pad;
		q = 0;
		r = 0;
		gap = 0;
		if (line_len == 0)
			return;
		len = line_len - 1;
		w = width_reg;
		pad = !final_line && word_cnt >= 2 && len <= w;
		if (pad) begin
			q = (w - len) / (word_cnt - 1);
			r = (w - len) % (word_cnt - 1);
		end
		for (int i = 0; i < len && i < tlj_pkg::MAX_WIDTH_DEF + 1; i++) begin
			emit(line_buf[i]);
			if (line_buf[i] == tlj_pkg::CH_SPACE && pad) begin
				for (int j = 0; j < q; j++)
					emit(tlj_pkg::CH_SPACE);
				if (gap < r)
					emit(tlj_pkg::CH_SPACE);
				gap++;
			end
		end
		if (!final_line)
			emit(tlj_pkg::CH_LF);
		line_len = 0;
		word_cnt = 0;
	endfunction

	function automatic void close_word();
		if (word_len + line_len + 1 >= width_reg)
			flush_line(1'b0);
		for (int i = 0; i < word_len && line_len < tlj_pkg::MAX_WIDTH_DEF + 1; i++) begin
			line_buf[line_len] = word_buf[i];
			line_len++;
		end
		if (line_len < tlj_pkg::MAX_WIDTH_DEF + 1) begin
			line_buf[line_len] = tlj_pkg::CH_SPACE;
			line_len++;
		end
		word_cnt++;
		word_len = 0;
	endfunction

	function automatic void clear_text();
		word_len = 0;
		line_len = 0;
		word_cnt = 0;
		in_gap = 1'b1;
	endfunction

	function automatic void justify(input logic [7:0] b, input logic eot);
		logic [7:0] c;
		step_q.delete();
		if (eot) begin
			if (!in_gap)
				close_word();
			flush_line(1'b1);
			clear_text();
		end else if (b == tlj_pkg::CH_SPACE || b == tlj_pkg::CH_LF || b == tlj_pkg::CH_TAB ||
				b == tlj_pkg::CH_BOM0 || b == tlj_pkg::CH_BOM1 || b == tlj_pkg::CH_BOM2) begin
			if (!in_gap) begin
				in_gap = 1'b1;
				close_word();
			end
		end else begin
			c = b[7] ? tlj_pkg::CH_QUEST : b;
			if (word_len < tlj_pkg::MAX_WIDTH_DEF) begin
				word_buf[word_len] = c;
				word_len++;
			end
			in_gap = 1'b0;
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			just_q.push_back(step_q[i]);
	endfunction

	task automatic send(input logic [7:0] b, input logic eot);
		@(negedge clk);
		while (!quiet_in && $urandom_range(99) < 13) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		while (full)
			@(negedge clk);
		@(posedge clk);
		justify(b, eot);
		pushed++;
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (just_q.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_width(input int unsigned w);
		@(negedge clk);
		push <= 1'b0;
		cfg_we <= 1'b1;
		cfg_wdata <= w[4:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		width_reg = (w[4:0] > tlj_pkg::MAX_WIDTH_DEF) ? tlj_pkg::MAX_WIDTH_DEF : w[4:0];
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i], 1'b0);
	endtask

	// Result side: random stalls, compare against the oldest expectation.
	always @(negedge clk)
		pop <= quiet_out ? 1'b1 : ($urandom_range(99) >= 13);

	always @(posedge clk) begin
		jbyte_t got, want;
		if (arst_n && pop && !empty) begin
			got = '{ch: out_byte, last: run_last};
			popped++;
			if (just_q.size() == 0) begin
				report("unexpected", got, got);
			end else begin
				want = just_q.pop_front();
				if (got.ch !== want.ch)
					report("out_byte", got, want);
				if (got.last !== want.last)
					report("run_last", got, want);
			end
		end
	end

	stim_row_t rows [] = '{
		'{8'h00, 1'b1, 1'b0, 8'h00},
		'{8'h41, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b1, 1'b1, 8'h41},
		'{8'hFF, 1'b0, 1'b0, 8'h00},
		'{8'h80, 1'b0, 1'b0, 8'h00},
		'{8'h7F, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b1, 1'b1, tlj_pkg::CH_QUEST},
		'{8'h42, 1'b0, 1'b0, 8'h00},
		'{tlj_pkg::CH_TAB, 1'b0, 1'b0, 8'h00},
		'{8'h43, 1'b0, 1'b0, 8'h00},
		'{tlj_pkg::CH_LF, 1'b0, 1'b0, 8'h00},
		'{8'h44, 1'b0, 1'b0, 8'h00},
		'{tlj_pkg::CH_BOM0, 1'b0, 1'b0, 8'h00},
		'{tlj_pkg::CH_BOM1, 1'b0, 1'b0, 8'h00},
		'{8'h45, 1'b0, 1'b0, 8'h00},
		'{tlj_pkg::CH_BOM2, 1'b0, 1'b0, 8'h00},
		'{tlj_pkg::CH_SPACE, 1'b0, 1'b0, 8'h00},
		'{8'h01, 1'b1, 1'b0, 8'h00}
	};

	initial begin
		string words [6] = '{"a", "bb", "ccc", "dddd", "eeeee", "ffffffffffff"};
		int unsigned widths [4] = '{12, 7, 1, 9};
		int n;
		int unsigned ph;
		width_reg = 31;
		clear_text();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].typed)
				drain();
			send(rows[i].text, rows[i].eot);
			if (rows[i].typed && just_q.size() > 0 && just_q[0].ch !== rows[i].out0)
				report("typed row", just_q[0], '{ch: rows[i].out0, last: 1'b0});
		end
		drain();

		// Width extremes with overlong words and lines.
		set_width(0);
		send_text("xy zz w ");
		send(8'h00, 1'b1);
		drain();
		set_width(31);
		for (int i = 0; i < 33; i++)
			send(8'h61 + 8'(i % 26), 1'b0);
		send_text(" q r s t");
		send(8'h00, 1'b1);
		drain();

		// Random: mostly words with random letters, some noise bytes.
		n = 0;
		ph = 0;
		while (n < 52) begin
			set_width(widths[ph % 4]);
			quiet_in = (ph == 2);
			quiet_out = (ph == 2);
			for (int k = 0; k < 12 && n < 52; k++) begin
				int r;
				r = $urandom_range(99);
				if (r < 60)
					send(8'(words[$urandom_range(5)][0] + $urandom_range(0, 3)), 1'b0);
				else if (r < 85)
					send(tlj_pkg::CH_SPACE, 1'b0);
				else
					send(8'($urandom_range(255)), 1'b0);
				n++;
			end
			send(8'h00, 1'b1);
			n++;
			drain();
			ph++;
		end
		drain();
		$display("Covered %0d pushed bytes and %0d justified bytes over %0d width settings.",
			pushed, popped, ph + 2);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end
endmodule
